### sv/scd_pkg.sv
// Shared constants, types and key tables for the scan code decoder.
`timescale 1ns / 1ps
`default_nettype none

package scd_pkg;

   localparam int unsigned SCAN_W = 8;
   localparam int unsigned MAKE_W = 7;
   localparam int unsigned CHAR_W = 7;
   localparam int unsigned TERM_W = 2;
   localparam int unsigned INDEX_W = 6;

   localparam logic [SCAN_W-1:0] PREFIX_CODE = 8'hE0;
   localparam logic [MAKE_W-1:0] TABLE_TOP = 7'h39;

   // Make codes with special handling
   localparam logic [MAKE_W-1:0] MK_CTRL = 7'h1D;
   localparam logic [MAKE_W-1:0] MK_LSHIFT = 7'h2A;
   localparam logic [MAKE_W-1:0] MK_RSHIFT = 7'h36;
   localparam logic [MAKE_W-1:0] MK_ALT = 7'h38;
   localparam logic [MAKE_W-1:0] MK_DELETE = 7'h53;
   localparam logic [MAKE_W-1:0] MK_CAPS = 7'h3A;
   localparam logic [MAKE_W-1:0] MK_NUM = 7'h45;
   localparam logic [MAKE_W-1:0] MK_SCROLL = 7'h46;
   localparam logic [MAKE_W-1:0] MK_F1 = 7'h3B;
   localparam logic [MAKE_W-1:0] MK_F4 = 7'h3E;
   localparam logic [MAKE_W-1:0] MK_UP = 7'h48;
   localparam logic [MAKE_W-1:0] MK_DOWN = 7'h50;
   localparam logic [MAKE_W-1:0] MK_RIGHT = 7'h4D;
   localparam logic [MAKE_W-1:0] MK_LEFT = 7'h4B;
   localparam logic [MAKE_W-1:0] MK_HOME = 7'h47;
   localparam logic [MAKE_W-1:0] MK_END = 7'h4F;

   // Escape sequence bytes
   localparam logic [CHAR_W-1:0] ASCII_ESC = 7'h1B;
   localparam logic [CHAR_W-1:0] ASCII_BRACKET = 7'h5B;
   localparam logic [CHAR_W-1:0] SEQ_UP = 7'h41;
   localparam logic [CHAR_W-1:0] SEQ_DOWN = 7'h42;
   localparam logic [CHAR_W-1:0] SEQ_RIGHT = 7'h43;
   localparam logic [CHAR_W-1:0] SEQ_LEFT = 7'h44;
   localparam logic [CHAR_W-1:0] SEQ_HOME = 7'h48;
   localparam logic [CHAR_W-1:0] SEQ_END = 7'h46;

   // Decoded result of one scan word, handed from decode to emit
   typedef struct packed {
      logic              has_char;
      logic [CHAR_W-1:0] char_code;
      logic              escape;
      logic [CHAR_W-1:0] esc_letter;
      logic              caps_led;
      logic              num_led;
      logic              scroll_led;
      logic              reboot_request;
      logic              switch_valid;
      logic [TERM_W-1:0] switch_terminal;
   } scd_result_type;

   function automatic logic [CHAR_W-1:0] plain_char(input logic [INDEX_W-1:0] idx);
      logic [CHAR_W-1:0] c;
      case (idx)
         6'h01: c = 7'h1B;
         6'h02: c = 7'h31;
         6'h03: c = 7'h32;
         6'h04: c = 7'h33;
         6'h05: c = 7'h34;
         6'h06: c = 7'h35;
         6'h07: c = 7'h36;
         6'h08: c = 7'h37;
         6'h09: c = 7'h38;
         6'h0A: c = 7'h39;
         6'h0B: c = 7'h30;
         6'h0C: c = 7'h2D;
         6'h0D: c = 7'h3D;
         6'h0E: c = 7'h08;
         6'h0F: c = 7'h09;
         6'h10: c = 7'h71;
         6'h11: c = 7'h77;
         6'h12: c = 7'h65;
         6'h13: c = 7'h72;
         6'h14: c = 7'h74;
         6'h15: c = 7'h79;
         6'h16: c = 7'h75;
         6'h17: c = 7'h69;
         6'h18: c = 7'h6F;
         6'h19: c = 7'h70;
         6'h1A: c = 7'h5B;
         6'h1B: c = 7'h5D;
         6'h1C: c = 7'h0A;
         6'h1E: c = 7'h61;
         6'h1F: c = 7'h73;
         6'h20: c = 7'h64;
         6'h21: c = 7'h66;
         6'h22: c = 7'h67;
         6'h23: c = 7'h68;
         6'h24: c = 7'h6A;
         6'h25: c = 7'h6B;
         6'h26: c = 7'h6C;
         6'h27: c = 7'h3B;
         6'h28: c = 7'h27;
         6'h29: c = 7'h60;
         6'h2C: c = 7'h7A;
         6'h2D: c = 7'h78;
         6'h2E: c = 7'h63;
         6'h2F: c = 7'h76;
         6'h30: c = 7'h62;
         6'h31: c = 7'h6E;
         6'h32: c = 7'h6D;
         6'h33: c = 7'h2C;
         6'h34: c = 7'h2E;
         6'h35: c = 7'h2F;
         6'h39: c = 7'h20;
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] shift_char(input logic [INDEX_W-1:0] idx);
      logic [CHAR_W-1:0] c;
      case (idx)
         6'h01: c = 7'h1B;
         6'h02: c = 7'h21;
         6'h03: c = 7'h40;
         6'h04: c = 7'h23;
         6'h05: c = 7'h24;
         6'h06: c = 7'h25;
         6'h07: c = 7'h5E;
         6'h08: c = 7'h26;
         6'h09: c = 7'h2A;
         6'h0A: c = 7'h28;
         6'h0B: c = 7'h29;
         6'h0C: c = 7'h5F;
         6'h0D: c = 7'h2B;
         6'h0E: c = 7'h08;
         6'h0F: c = 7'h09;
         6'h10: c = 7'h51;
         6'h11: c = 7'h57;
         6'h12: c = 7'h45;
         6'h13: c = 7'h52;
         6'h14: c = 7'h54;
         6'h15: c = 7'h59;
         6'h16: c = 7'h55;
         6'h17: c = 7'h49;
         6'h18: c = 7'h4F;
         6'h19: c = 7'h50;
         6'h1A: c = 7'h7B;
         6'h1B: c = 7'h7D;
         6'h1C: c = 7'h0A;
         6'h1E: c = 7'h41;
         6'h1F: c = 7'h53;
         6'h20: c = 7'h44;
         6'h21: c = 7'h46;
         6'h22: c = 7'h47;
         6'h23: c = 7'h48;
         6'h24: c = 7'h4A;
         6'h25: c = 7'h4B;
         6'h26: c = 7'h4C;
         6'h27: c = 7'h3A;
         6'h28: c = 7'h22;
         6'h29: c = 7'h7E;
         6'h2C: c = 7'h5A;
         6'h2D: c = 7'h58;
         6'h2E: c = 7'h43;
         6'h2F: c = 7'h56;
         6'h30: c = 7'h42;
         6'h31: c = 7'h4E;
         6'h32: c = 7'h4D;
         6'h33: c = 7'h3C;
         6'h34: c = 7'h3E;
         6'h35: c = 7'h3F;
         6'h39: c = 7'h20;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

### sv/scd_if.sv
// Valid/ready channel interfaces for scan words in and decoded words out.
`timescale 1ns / 1ps
`default_nettype none

interface scd_req_if;
   import scd_pkg::*;
   logic              valid;
   logic              ready;
   logic [SCAN_W-1:0] scan_code;

   modport source (output valid, output scan_code, input ready);
   modport sink (input valid, input scan_code, output ready);
endinterface

interface scd_rsp_if;
   import scd_pkg::*;
   logic              valid;
   logic              ready;
   logic              has_char;
   logic [CHAR_W-1:0] char_code;
   logic              last_of_run;
   logic              caps_led;
   logic              num_led;
   logic              scroll_led;
   logic              reboot_request;
   logic              switch_valid;
   logic [TERM_W-1:0] switch_terminal;

   modport source (output valid, output has_char, output char_code, output last_of_run,
                   output caps_led, output num_led, output scroll_led,
                   output reboot_request, output switch_valid, output switch_terminal,
                   input ready);
   modport sink (input valid, input has_char, input char_code, input last_of_run,
                 input caps_led, input num_led, input scroll_led,
                 input reboot_request, input switch_valid, input switch_terminal,
                 output ready);
endinterface

`default_nettype wire

### sv/scancode_to_ascii_decoder_core.sv
// Top level of the set-1 scan code to ASCII decoder.
//
// Usage:
//  - req_if carries raw set-1 scan words (0xE0 prefix, bit 7 = release).
//    A word is taken at a clock edge with valid and ready both high.
//  - rsp_if carries decoded words: a character (or no character), the LED
//    states, reboot request and terminal switch flags. last_of_run marks
//    the final response word of each scan word.
//  - Every scan word yields one response word, except cursor key presses
//    (arrows, home, end) with prefix or num lock off, which yield ESC '[' letter as three words.
//  - Path: req accept loads the input register, then the word is decoded
//    into the response register, which drives rsp valid.
//  - Throughput: one scan word per cycle for single-word results while
//    rsp_if.ready stays high; an escape run holds the response register
//    until all three of its words have been taken.
//  - The input register takes a new word while a finished response still
//    waits; if rsp_if.ready stays low, both stages fill and req_if.ready
//    drops until the receiver takes the last word of the pending run.
//  - Reset (synchronous, active high) clears all held keys, lock states,
//    the prefix flag and both stage valids; nothing is in flight after it.
`timescale 1ns / 1ps
`default_nettype none

module scancode_to_ascii_decoder_core (
   input  wire logic clock,
   input  wire logic reset,
   scd_req_if.sink   req_if,
   scd_rsp_if.source rsp_if
);
   import scd_pkg::*;

   logic              in_valid_ff;
   logic [SCAN_W-1:0] scan_ff;
   logic              advance;
   logic              out_free;
   scd_result_type    result;

   // decode a held word once the response register can take it
   assign advance = in_valid_ff && out_free;
   assign req_if.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.valid && req_if.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         scan_ff <= req_if.scan_code;
      end
   end

   scd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .scan_code (scan_ff),
      .result    (result)
   );

   scd_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .result   (result),
      .out_free (out_free),
      .rsp_if   (rsp_if)
   );

endmodule

`default_nettype wire

### sv/scd_decode.sv
// Key state registers and single-pass decode of one scan word.
`timescale 1ns / 1ps
`default_nettype none

module scd_decode (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  wire logic [scd_pkg::SCAN_W-1:0] scan_code,
   output scd_pkg::scd_result_type        result
);
   import scd_pkg::*;

   logic ctrl_ff, alt_ff, shift_ff, caps_ff, num_ff, scroll_ff, prefix_ff;
   logic ctrl_in, alt_in, shift_in, caps_in, num_in, scroll_in, prefix_in;

   logic              release_key;
   logic [MAKE_W-1:0] make;
   logic [CHAR_W-1:0] ch;
   logic              cursor_ok;

   assign release_key = scan_code[SCAN_W-1];
   assign make = scan_code[MAKE_W-1:0];
   assign cursor_ok = !release_key && (prefix_ff || !num_ff);

   always_comb begin
      ch = '0;
      if (!prefix_ff && make <= TABLE_TOP) begin
         ch = (shift_ff || caps_ff) ? shift_char(make[INDEX_W-1:0])
                                    : plain_char(make[INDEX_W-1:0]);
      end
   end

   always_comb begin
      ctrl_in = ctrl_ff;
      alt_in = alt_ff;
      shift_in = shift_ff;
      caps_in = caps_ff;
      num_in = num_ff;
      scroll_in = scroll_ff;
      prefix_in = 1'b0;
      result = '0;
      if (scan_code == PREFIX_CODE) begin
         prefix_in = 1'b1;
      end else if (ch != '0) begin
         // mapped key: release gives nothing
         result.has_char = !release_key;
         result.char_code = release_key ? '0 : ch;
      end else begin
         case (make)
            MK_CTRL: ctrl_in = !release_key;
            MK_LSHIFT, MK_RSHIFT: shift_in = !release_key;
            MK_ALT: alt_in = !release_key;
            MK_DELETE: result.reboot_request = alt_ff && ctrl_ff && prefix_ff;
            MK_CAPS: if (!release_key) caps_in = !caps_ff;
            MK_NUM: if (!release_key) num_in = !num_ff;
            MK_SCROLL: if (!release_key) scroll_in = !scroll_ff;
            MK_UP: begin
               result.escape = cursor_ok;
               result.esc_letter = SEQ_UP;
            end
            MK_DOWN: begin
               result.escape = cursor_ok;
               result.esc_letter = SEQ_DOWN;
            end
            MK_RIGHT: begin
               result.escape = cursor_ok;
               result.esc_letter = SEQ_RIGHT;
            end
            MK_LEFT: begin
               result.escape = cursor_ok;
               result.esc_letter = SEQ_LEFT;
            end
            MK_HOME: begin
               result.escape = cursor_ok;
               result.esc_letter = SEQ_HOME;
            end
            MK_END: begin
               result.escape = cursor_ok;
               result.esc_letter = SEQ_END;
            end
            default: begin
               if (make inside {[MK_F1:MK_F4]}) begin
                  result.switch_valid = 1'b1;
                  result.switch_terminal = TERM_W'(make - MK_F1);
               end
            end
         endcase
      end
      result.caps_led = caps_in;
      result.num_led = num_in;
      result.scroll_led = scroll_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= 1'b0;
         alt_ff <= 1'b0;
         shift_ff <= 1'b0;
         caps_ff <= 1'b0;
         num_ff <= 1'b0;
         scroll_ff <= 1'b0;
         prefix_ff <= 1'b0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
         alt_ff <= alt_in;
         shift_ff <= shift_in;
         caps_ff <= caps_in;
         num_ff <= num_in;
         scroll_ff <= scroll_in;
         prefix_ff <= prefix_in;
      end
   end

endmodule

`default_nettype wire

### sv/scd_emit.sv
// Result register; steps through ESC '[' letter for cursor keys.
`timescale 1ns / 1ps
`default_nettype none

module scd_emit (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire scd_pkg::scd_result_type result,
   output logic                         out_free,
   scd_rsp_if.source                    rsp_if
);
   import scd_pkg::*;

   localparam logic [1:0] STEP_SINGLE = 2'd0;
   localparam logic [1:0] STEP_ESC = 2'd1;
   localparam logic [1:0] STEP_BRACKET = 2'd2;
   localparam logic [1:0] STEP_LETTER = 2'd3;

   logic              valid_ff;
   logic [1:0]        step_ff;
   logic [CHAR_W-1:0] letter_ff;
   scd_result_type    res_ff;
   logic              last_w;
   logic              take;

   assign last_w = (step_ff == STEP_SINGLE) || (step_ff == STEP_LETTER);
   assign take = valid_ff && rsp_if.ready;
   assign out_free = !valid_ff || (rsp_if.ready && last_w);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (take && last_w) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= result;
         letter_ff <= result.esc_letter;
         step_ff <= result.escape ? STEP_ESC : STEP_SINGLE;
      end else if (take) begin
         case (step_ff)
            STEP_ESC: step_ff <= STEP_BRACKET;
            STEP_BRACKET: step_ff <= STEP_LETTER;
            default: step_ff <= step_ff;
         endcase
      end
   end

   always_comb begin
      rsp_if.valid = valid_ff;
      rsp_if.last_of_run = last_w;
      rsp_if.caps_led = res_ff.caps_led;
      rsp_if.num_led = res_ff.num_led;
      rsp_if.scroll_led = res_ff.scroll_led;
      rsp_if.has_char = res_ff.has_char;
      rsp_if.char_code = res_ff.char_code;
      rsp_if.reboot_request = res_ff.reboot_request;
      rsp_if.switch_valid = res_ff.switch_valid;
      rsp_if.switch_terminal = res_ff.switch_terminal;
      case (step_ff)
         STEP_ESC: begin
            rsp_if.has_char = 1'b1;
            rsp_if.char_code = ASCII_ESC;
         end
         STEP_BRACKET: begin
            rsp_if.has_char = 1'b1;
            rsp_if.char_code = ASCII_BRACKET;
         end
         STEP_LETTER: begin
            rsp_if.has_char = 1'b1;
            rsp_if.char_code = letter_ff;
         end
         default: ;
      endcase
      if (step_ff != STEP_SINGLE) begin
         rsp_if.reboot_request = 1'b0;
         rsp_if.switch_valid = 1'b0;
         rsp_if.switch_terminal = '0;
      end
   end

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking bench for the scan code decoder: directed script, then random keystroke runs.
`timescale 1ns / 1ps

module testbench;
   import scd_pkg::*;

   // One decoded response word, laid out as the rsp channel carries it
   typedef struct packed {
      logic              has_char;
      logic [CHAR_W-1:0] char_code;
      logic              last_of_run;
      logic              caps_led;
      logic              num_led;
      logic              scroll_led;
      logic              reboot_request;
      logic              switch_valid;
      logic [TERM_W-1:0] switch_terminal;
   } key_word_type;

   // Directed script row; typed rows carry their single response word
   typedef struct {
      logic [SCAN_W-1:0] code;
      bit                typed;
      key_word_type      word;
   } script_row_type;

   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned RANDOM_WORDS = 360;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned STALL_PERIOD = 160;

   logic clock = 1'b0;
   logic reset;

   scd_req_if req_if ();
   scd_rsp_if rsp_if ();

   scancode_to_ascii_decoder_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #5 clock = ~clock;

   // Set-1 key maps, indexed by make code 0x00..0x39
   logic [CHAR_W-1:0] plain_keys [58] = '{
      7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
      7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
      7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
      7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
      7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h00, 7'h7A, 7'h78, 7'h63, 7'h76,
      7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00,
      7'h00, 7'h20
   };

   logic [CHAR_W-1:0] upper_keys [58] = '{
      7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
      7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
      7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
      7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
      7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h00, 7'h5A, 7'h58, 7'h43, 7'h56,
      7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00,
      7'h00, 7'h20
   };

   logic [MAKE_W-1:0] cursor_keys [6] = '{MK_UP, MK_DOWN, MK_RIGHT, MK_LEFT, MK_HOME, MK_END};
   logic [MAKE_W-1:0] lock_keys [3] = '{MK_CAPS, MK_NUM, MK_SCROLL};
   logic [MAKE_W-1:0] modifier_keys [4] = '{MK_CTRL, MK_LSHIFT, MK_RSHIFT, MK_ALT};

   // Keyboard state as the decoder should hold it
   logic ctrl_down = 1'b0;
   logic alt_down = 1'b0;
   logic shift_down = 1'b0;
   logic caps_on = 1'b0;
   logic num_on = 1'b0;
   logic scroll_on = 1'b0;
   logic prefix_pending = 1'b0;

   key_word_type   decoded_words [$];   // words caused by the last scan byte
   key_word_type   pending_words [$];   // words still owed by the decoder
   script_row_type script [$];
   key_word_type   got_word;
   key_word_type   want_word;

   int unsigned failures = 0;
   int unsigned sent_count = 0;
   int unsigned burst_left = 0;
   int unsigned cycle_count = 0;
   int unsigned stall_mode = 0;

   function automatic key_word_type word_of(input logic has, input logic [CHAR_W-1:0] ch,
                                            input logic last, input logic caps,
                                            input logic num, input logic scroll,
                                            input logic reboot, input logic sw,
                                            input logic [TERM_W-1:0] term);
      key_word_type w;
      w.has_char = has;
      w.char_code = has ? ch : '0;
      w.last_of_run = last;
      w.caps_led = caps;
      w.num_led = num;
      w.scroll_led = scroll;
      w.reboot_request = reboot;
      w.switch_valid = sw;
      w.switch_terminal = sw ? term : '0;
      return w;
   endfunction

   // Advance the keyboard state by one scan byte and list the words it causes
   task automatic decode_scan(input logic [SCAN_W-1:0] code);
      logic              is_break;
      logic              was_prefixed;
      logic              cursor_ok;
      logic [MAKE_W-1:0] make_code;
      logic [CHAR_W-1:0] ch;
      logic [CHAR_W-1:0] seq;
      logic              reboot;
      logic              sw;
      logic [TERM_W-1:0] term;

      decoded_words.delete();
      if (code == PREFIX_CODE) begin
         prefix_pending = 1'b1;
         decoded_words.push_back(word_of(1'b0, '0, 1'b1, caps_on, num_on, scroll_on,
                                         1'b0, 1'b0, '0));
         return;
      end

      is_break = code[SCAN_W-1];
      make_code = code[MAKE_W-1:0];
      was_prefixed = prefix_pending;
      ch = '0;
      seq = '0;
      reboot = 1'b0;
      sw = 1'b0;
      term = '0;

      // prefixed bytes never hit the key maps
      if (!was_prefixed && make_code <= TABLE_TOP)
         ch = (shift_down || caps_on) ? upper_keys[make_code] : plain_keys[make_code];

      if (ch != '0) begin
         if (is_break)
            ch = '0;
      end else begin
         // cursor keys pass when prefixed or when num lock is off
         cursor_ok = !is_break && (was_prefixed || !num_on);
         case (make_code)
            MK_CTRL: ctrl_down = !is_break;
            MK_LSHIFT, MK_RSHIFT: shift_down = !is_break;
            MK_ALT: alt_down = !is_break;
            MK_DELETE: reboot = alt_down && ctrl_down && was_prefixed;
            MK_CAPS: if (!is_break) caps_on = !caps_on;
            MK_NUM: if (!is_break) num_on = !num_on;
            MK_SCROLL: if (!is_break) scroll_on = !scroll_on;
            MK_UP: if (cursor_ok) seq = SEQ_UP;
            MK_DOWN: if (cursor_ok) seq = SEQ_DOWN;
            MK_RIGHT: if (cursor_ok) seq = SEQ_RIGHT;
            MK_LEFT: if (cursor_ok) seq = SEQ_LEFT;
            MK_HOME: if (cursor_ok) seq = SEQ_HOME;
            MK_END: if (cursor_ok) seq = SEQ_END;
            default: begin
               // F1..F4 switch terminals on press and on release
               if (make_code inside {[MK_F1:MK_F4]}) begin
                  sw = 1'b1;
                  term = TERM_W'(make_code - MK_F1);
               end
            end
         endcase
      end

      prefix_pending = 1'b0;

      if (seq != '0) begin
         decoded_words.push_back(word_of(1'b1, ASCII_ESC, 1'b0, caps_on, num_on, scroll_on,
                                         1'b0, 1'b0, '0));
         decoded_words.push_back(word_of(1'b1, ASCII_BRACKET, 1'b0, caps_on, num_on,
                                         scroll_on, 1'b0, 1'b0, '0));
         decoded_words.push_back(word_of(1'b1, seq, 1'b1, caps_on, num_on, scroll_on,
                                         1'b0, 1'b0, '0));
      end else begin
         decoded_words.push_back(word_of(ch != '0, ch, 1'b1, caps_on, num_on, scroll_on,
                                         reboot, sw, term));
      end
   endtask

   // Drive one scan word; the sender runs in bursts with idle gaps between them
   task automatic send_scan(input logic [SCAN_W-1:0] code, input bit typed,
                            input key_word_type typed_word);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 7)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 48 : $urandom_range(1, 10);
      end
      req_if.valid <= 1'b1;
      req_if.scan_code <= code;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      decode_scan(code);
      if (typed)
         pending_words.push_back(typed_word);
      else
         foreach (decoded_words[i]) pending_words.push_back(decoded_words[i]);
      sent_count++;
      burst_left--;
      if (burst_left == 0)
         req_if.valid <= 1'b0;
   endtask

   task automatic tap_key(input logic [MAKE_W-1:0] make_code, input bit prefixed);
      if (prefixed)
         send_scan(PREFIX_CODE, 1'b0, '0);
      send_scan({1'b0, make_code}, 1'b0, '0);
      if (prefixed)
         send_scan(PREFIX_CODE, 1'b0, '0);
      send_scan({1'b1, make_code}, 1'b0, '0);
   endtask

   // Mostly realistic keystrokes with random content, some broken sequences and noise
   task automatic run_random_keys(input int unsigned stop_at);
      int unsigned       pick;
      bit                shifted;
      logic [MAKE_W-1:0] shift_key;
      logic [MAKE_W-1:0] make_code;

      while (sent_count < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            make_code = MAKE_W'($urandom_range(0, TABLE_TOP));
            shifted = ($urandom_range(0, 2) == 0);
            shift_key = $urandom_range(0, 1) ? MK_LSHIFT : MK_RSHIFT;
            if (shifted)
               send_scan({1'b0, shift_key}, 1'b0, '0);
            tap_key(make_code, 1'b0);
            if (shifted)
               send_scan({1'b1, shift_key}, 1'b0, '0);
         end else if (pick < 50) begin
            tap_key(lock_keys[$urandom_range(0, 2)], 1'b0);
         end else if (pick < 64) begin
            tap_key(cursor_keys[$urandom_range(0, 5)], 1'($urandom_range(0, 1)));
         end else if (pick < 72) begin
            tap_key(MAKE_W'(MK_F1 + $urandom_range(0, 5)), $urandom_range(0, 3) == 0);
         end else if (pick < 80) begin
            // ctrl+alt+delete, now and then with a modifier or the prefix missing
            if ($urandom_range(0, 3) != 0)
               send_scan({1'b0, MK_CTRL}, 1'b0, '0);
            if ($urandom_range(0, 1) != 0)
               send_scan(PREFIX_CODE, 1'b0, '0);
            if ($urandom_range(0, 3) != 0)
               send_scan({1'b0, MK_ALT}, 1'b0, '0);
            tap_key(MK_DELETE, $urandom_range(0, 4) != 0);
            send_scan({1'b1, MK_ALT}, 1'b0, '0);
            send_scan({1'b1, MK_CTRL}, 1'b0, '0);
         end else if (pick < 88) begin
            if ($urandom_range(0, 2) == 0)
               send_scan(PREFIX_CODE, 1'b0, '0);
            send_scan({1'($urandom_range(0, 1)), modifier_keys[$urandom_range(0, 3)]},
                      1'b0, '0);
         end else begin
            if ($urandom_range(0, 3) == 0)
               send_scan(PREFIX_CODE, 1'b0, '0);
            send_scan(SCAN_W'($urandom_range(0, 255)), 1'b0, '0);
         end
      end
   endtask

   task automatic report_field(input string field, input logic [7:0] want_v,
                               input logic [7:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
         failures++;
      end
   endtask

   // Cycle counter, timeout and the receiver's stall pattern
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
      if (cycle_count % STALL_PERIOD == 0)
         stall_mode <= $urandom_range(0, 2);
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(0, 9) < 7);
            default: rsp_if.ready <= ((cycle_count % 5) < 2);
         endcase
      end
   end

   // Compare every accepted response word with the oldest one owed
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got_word.has_char = rsp_if.has_char;
         got_word.char_code = rsp_if.char_code;
         got_word.last_of_run = rsp_if.last_of_run;
         got_word.caps_led = rsp_if.caps_led;
         got_word.num_led = rsp_if.num_led;
         got_word.scroll_led = rsp_if.scroll_led;
         got_word.reboot_request = rsp_if.reboot_request;
         got_word.switch_valid = rsp_if.switch_valid;
         got_word.switch_terminal = rsp_if.switch_terminal;
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected response word, expected none, actual %h",
                     $time, got_word);
            failures++;
         end else begin
            want_word = pending_words.pop_front();
            report_field("has_char", want_word.has_char, got_word.has_char);
            report_field("char_code", want_word.char_code, got_word.char_code);
            report_field("last_of_run", want_word.last_of_run, got_word.last_of_run);
            report_field("caps_led", want_word.caps_led, got_word.caps_led);
            report_field("num_led", want_word.num_led, got_word.num_led);
            report_field("scroll_led", want_word.scroll_led, got_word.scroll_led);
            report_field("reboot_request", want_word.reboot_request,
                         got_word.reboot_request);
            report_field("switch_valid", want_word.switch_valid, got_word.switch_valid);
            report_field("switch_terminal", want_word.switch_terminal,
                         got_word.switch_terminal);
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.scan_code = '0;
      rsp_if.ready = 1'b0;

      // Directed script: LEDs read caps, num, scroll in that order
      script.push_back('{8'h00, 1'b1, word_of(0, '0, 1, 0, 0, 0, 0, 0, '0)});
      script.push_back('{8'h1E, 1'b1, word_of(1, 7'h61, 1, 0, 0, 0, 0, 0, '0)});
      script.push_back('{8'h9E, 1'b1, word_of(0, '0, 1, 0, 0, 0, 0, 0, '0)});
      script.push_back('{{1'b0, MK_LSHIFT}, 1'b0, '0});
      script.push_back('{8'h10, 1'b0, '0});
      // right shift release clears the shared shift bit
      script.push_back('{{1'b1, MK_RSHIFT}, 1'b0, '0});
      script.push_back('{{1'b0, MK_CAPS}, 1'b1, word_of(0, '0, 1, 1, 0, 0, 0, 0, '0)});
      script.push_back('{8'h35, 1'b0, '0});
      script.push_back('{{1'b0, MK_UP}, 1'b0, '0});
      script.push_back('{{1'b0, MK_NUM}, 1'b1, word_of(0, '0, 1, 1, 1, 0, 0, 0, '0)});
      // num lock on: bare cursor key is swallowed
      script.push_back('{{1'b0, MK_END}, 1'b0, '0});
      script.push_back('{PREFIX_CODE, 1'b1, word_of(0, '0, 1, 1, 1, 0, 0, 0, '0)});
      script.push_back('{PREFIX_CODE, 1'b1, word_of(0, '0, 1, 1, 1, 0, 0, 0, '0)});
      script.push_back('{{1'b0, MK_END}, 1'b0, '0});
      script.push_back('{{1'b0, MK_SCROLL}, 1'b1, word_of(0, '0, 1, 1, 1, 1, 0, 0, '0)});
      script.push_back('{{1'b0, MK_F1}, 1'b1, word_of(0, '0, 1, 1, 1, 1, 0, 1, 2'd0)});
      script.push_back('{{1'b1, MK_F4}, 1'b1, word_of(0, '0, 1, 1, 1, 1, 0, 1, 2'd3)});
      script.push_back('{{1'b0, MK_CTRL}, 1'b0, '0});
      script.push_back('{PREFIX_CODE, 1'b0, '0});
      script.push_back('{{1'b0, MK_ALT}, 1'b0, '0});
      script.push_back('{PREFIX_CODE, 1'b0, '0});
      script.push_back('{{1'b0, MK_DELETE}, 1'b1, word_of(0, '0, 1, 1, 1, 1, 1, 0, '0)});
      // prefixed table key maps to nothing
      script.push_back('{PREFIX_CODE, 1'b0, '0});
      script.push_back('{8'h1E, 1'b0, '0});
      script.push_back('{8'h7F, 1'b1, word_of(0, '0, 1, 1, 1, 1, 0, 0, '0)});
      script.push_back('{8'hFF, 1'b1, word_of(0, '0, 1, 1, 1, 1, 0, 0, '0)});

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) send_scan(script[i].code, script[i].typed, script[i].word);
      run_random_keys(script.size() + RANDOM_WORDS);
      if (burst_left != 0)
         req_if.valid <= 1'b0;

      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
